>>> rtl/vlti_pkg.sv
package vlti_pkg;

    localparam int MCLK_PER_LINE_DEFAULT = 3420;
    localparam int LINE_CLOCK_W          = 12;
    localparam int H40_DOTS              = 420;
    localparam int H32_DOTS              = 342;

    // horizontal counter mapping
    localparam logic [11:0] H40_OFFSET  = 12'hD;
    localparam logic [11:0] H32_OFFSET  = 12'hB;
    localparam logic [11:0] H40_JUMP_AT = 12'h16D;
    localparam logic [11:0] H32_JUMP_AT = 12'h128;
    localparam logic [11:0] H40_JUMP    = 12'(12'h1C9 - 12'h16D);
    localparam logic [11:0] H32_JUMP    = 12'(12'h1D2 - 12'h128);

    // vertical counter mapping
    localparam logic [8:0] V_PAL240_AT   = 9'h10B;
    localparam logic [8:0] V_PAL224_AT   = 9'h103;
    localparam logic [8:0] V_NTSC_AT     = 9'h0EB;
    localparam logic [9:0] V_PAL240_JUMP = 10'(10'h1D2 - 10'h10B);
    localparam logic [9:0] V_PAL224_JUMP = 10'(10'h1CA - 10'h103);
    localparam logic [9:0] V_NTSC_JUMP   = 10'(10'h1E5 - 10'h0EB);

    localparam logic [8:0] VB_START_240 = 9'h0F0;
    localparam logic [8:0] VB_START_224 = 9'h0E0;
    localparam logic [8:0] LINES_PAL    = 9'd313;
    localparam logic [8:0] LINES_NTSC   = 9'd262;
    localparam logic [8:0] V_MAX        = 9'h1FF;

    localparam logic [8:0] H40_HBLANK_END   = 9'h00A;
    localparam logic [8:0] H40_HBLANK_START = 9'h166;
    localparam logic [8:0] H32_HBLANK_END   = 9'h009;
    localparam logic [8:0] H32_HBLANK_START = 9'h126;

    localparam logic [15:0] STATUS_BASE = 16'h3C00;
    localparam logic [15:0] FIFO_EMPTY  = 16'h0200;
    localparam logic [15:0] ACK_HINT_PENDING = 16'h0004;

    typedef enum logic [2:0] {
        ACT_LINE_END = 3'd0,
        ACT_ACK6     = 3'd1,
        ACT_ACK4     = 3'd2,
        ACT_STATUS   = 3'd3,
        ACT_HV_READ  = 3'd4
    } t_action;

    typedef enum logic [2:0] {
        CFG_LINE_RELOAD   = 3'd0,
        CFG_LINE_INT_EN   = 3'd1,
        CFG_VBLANK_INT_EN = 3'd2,
        CFG_DISPLAY_EN    = 3'd3,
        CFG_PAL_MODE      = 3'd4,
        CFG_WIDE_MODE     = 3'd5,
        CFG_PAL_CONSOLE   = 3'd6
    } t_cfg_idx;

    typedef struct packed {
        logic [7:0] line_reload;
        logic       line_int_en;
        logic       vblank_int_en;
        logic       display_en;
        logic       pal_mode;
        logic       wide_mode;
        logic       pal_console;
    } t_cfg;

    typedef struct packed {
        logic        z80_irq;
        logic        raise_level6;
        logic        raise_level4;
        logic [8:0]  render_line;
        logic [15:0] read_data;
    } t_result;

endpackage

>>> rtl/vlti_hv_map.sv
module vlti_hv_map
    import vlti_pkg::*;
#(
    parameter int MASTER_CLOCKS_PER_LINE = MCLK_PER_LINE_DEFAULT
) (
    input  t_cfg                    i_cfg,
    input  logic [8:0]              i_line_index,
    input  logic [LINE_CLOCK_W-1:0] i_line_clock,
    output logic [8:0]              o_hcount,
    output logic [8:0]              o_vcount
);

    // floor(clk * dots / M) as one multiply by a scaled reciprocal, exact over the clock range
    localparam int NUM_W = $clog2((2 ** LINE_CLOCK_W) * H40_DOTS);
    localparam int SHIFT = NUM_W + $clog2(MASTER_CLOCKS_PER_LINE);
    localparam longint unsigned RECIP =
        ((64'd1 << SHIFT) + 64'(MASTER_CLOCKS_PER_LINE) - 64'd1) / 64'(MASTER_CLOCKS_PER_LINE);
    localparam longint unsigned K40 = 64'(H40_DOTS) * RECIP;
    localparam longint unsigned K32 = 64'(H32_DOTS) * RECIP;
    localparam int KW = $clog2(K40 + 64'd1);
    localparam int PW = LINE_CLOCK_W + KW;

    logic [KW-1:0] k_sel;
    logic [PW-1:0] prod;
    logic [11:0]   h_pos;
    logic [11:0]   h_adj;
    logic [9:0]    v_adj;

    always_comb begin
        k_sel = i_cfg.wide_mode ? KW'(K40) : KW'(K32);
        prod  = PW'(i_line_clock) * PW'(k_sel);
        h_pos = 12'(prod[PW-1:SHIFT]) + (i_cfg.wide_mode ? H40_OFFSET : H32_OFFSET);
        if (i_cfg.wide_mode) begin
            h_adj = (h_pos >= H40_JUMP_AT) ? h_pos + H40_JUMP : h_pos;
        end else begin
            h_adj = (h_pos >= H32_JUMP_AT) ? h_pos + H32_JUMP : h_pos;
        end
        o_hcount = h_adj[8:0];

        v_adj = {1'b0, i_line_index};
        if (i_cfg.pal_console && i_cfg.pal_mode && i_line_index >= V_PAL240_AT) begin
            v_adj = v_adj + V_PAL240_JUMP;
        end else if (i_cfg.pal_console && !i_cfg.pal_mode && i_line_index >= V_PAL224_AT) begin
            v_adj = v_adj + V_PAL224_JUMP;
        end else if (!i_cfg.pal_console && i_line_index >= V_NTSC_AT) begin
            v_adj = v_adj + V_NTSC_JUMP;
        end
        o_vcount = v_adj[8:0];
    end

endmodule

>>> rtl/vlti_core.sv
module vlti_core
    import vlti_pkg::*;
#(
    parameter int MASTER_CLOCKS_PER_LINE = MCLK_PER_LINE_DEFAULT
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  t_cfg                    i_cfg,
    input  logic                    i_step,
    input  logic [2:0]              i_action,
    input  logic [LINE_CLOCK_W-1:0] i_line_clock,
    output t_result                 o_result
);

    logic [8:0] r_line_idx, n_line_idx;
    logic [7:0] r_countdown, n_countdown;
    logic       r_hint, n_hint;
    logic       r_vint, n_vint;
    logic       r_z80, n_z80;

    logic [8:0] hcount, vcount;
    logic [8:0] vb_start, total, next_idx;
    logic [7:0] cd_base;
    logic       vblank, hblank;

    vlti_hv_map #(
        .MASTER_CLOCKS_PER_LINE(MASTER_CLOCKS_PER_LINE)
    ) u_hv_map (
        .i_cfg       (i_cfg),
        .i_line_index(r_line_idx),
        .i_line_clock(i_line_clock),
        .o_hcount    (hcount),
        .o_vcount    (vcount)
    );

    always_comb begin
        vb_start = i_cfg.pal_mode ? VB_START_240 : VB_START_224;
        total    = i_cfg.pal_console ? LINES_PAL : LINES_NTSC;
        vblank   = !i_cfg.display_en || (vcount >= vb_start && vcount < V_MAX);
        hblank   = i_cfg.wide_mode ? (hcount < H40_HBLANK_END || hcount >= H40_HBLANK_START)
                                   : (hcount < H32_HBLANK_END || hcount >= H32_HBLANK_START);

        n_line_idx  = r_line_idx;
        n_countdown = r_countdown;
        n_hint      = r_hint;
        n_vint      = r_vint;
        n_z80       = r_z80;
        cd_base     = r_countdown;
        next_idx    = 9'(r_line_idx + 9'd1);

        o_result              = '0;
        o_result.render_line  = r_line_idx;

        case (t_action'(i_action))
            ACT_LINE_END: begin
                // reload in vblank and at the top of the frame
                if (r_line_idx == 9'd0 || r_line_idx >= 9'(vb_start + 9'd1)) begin
                    cd_base = i_cfg.line_reload;
                end
                if (cd_base == 8'd0) begin
                    if (i_cfg.line_int_en && r_line_idx <= vb_start) begin
                        n_hint = 1'b1;
                        o_result.raise_level4 = !r_vint;
                    end
                    n_countdown = i_cfg.line_reload;
                end else begin
                    n_countdown = cd_base - 8'd1;
                end
                if (next_idx >= total) begin
                    next_idx = '0;
                end
                n_line_idx = next_idx;
                if (next_idx == vb_start) begin
                    if (i_cfg.vblank_int_en) begin
                        n_vint = 1'b1;
                        o_result.raise_level6 = 1'b1;
                    end
                    n_z80 = 1'b1;
                end
                if (next_idx == 9'(vb_start + 9'd1)) begin
                    n_z80 = 1'b0;
                end
            end
            ACT_ACK6: begin
                n_vint = 1'b0;
                o_result.read_data = r_hint ? ACK_HINT_PENDING : 16'd0;
            end
            ACT_ACK4: begin
                n_hint = 1'b0;
            end
            ACT_STATUS: begin
                o_result.read_data = STATUS_BASE | FIFO_EMPTY
                                   | {8'd0, r_vint, 3'd0, vblank, hblank, 1'b0, i_cfg.pal_mode};
            end
            ACT_HV_READ: begin
                o_result.read_data = {vcount[7:0], hcount[8:1]};
            end
            default: begin
            end
        endcase

        o_result.z80_irq = n_z80;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_line_idx  <= '0;
            r_countdown <= '0;
            r_hint      <= 1'b0;
            r_vint      <= 1'b0;
            r_z80       <= 1'b0;
        end else if (i_step) begin
            r_line_idx  <= n_line_idx;
            r_countdown <= n_countdown;
            r_hint      <= n_hint;
            r_vint      <= n_vint;
            r_z80       <= n_z80;
        end
    end

`ifndef SYNTH
    a_line_in_frame: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_line_idx < LINES_PAL)
        else $error("line index beyond longest frame");

    a_z80_on_line_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_z80) |-> $past(i_step && i_action == ACT_LINE_END))
        else $error("z80 irq raised outside a line end");

    a_vint_on_line_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_vint) |-> $past(i_step && i_action == ACT_LINE_END && i_cfg.vblank_int_en))
        else $error("vint pending set outside an enabled line end");
`endif

endmodule

>>> rtl/video_line_timing_and_interrupts_top.sv
// Path: an accepted item sits in the input register, moves to the result register when the
// result register is empty or being taken, and is offered on the master side from then on.
// Throughput: one item per cycle while the master side takes results; the horizontal counter
// path is one constant-reciprocal multiply between the input and result registers.
// Reset: synchronous, active low; clears line state, pending flags and all configuration to 0.
module video_line_timing_and_interrupts_top
    import vlti_pkg::*;
#(
    parameter int MASTER_CLOCKS_PER_LINE = MCLK_PER_LINE_DEFAULT
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [2:0]  i_cfg_addr,
    input  logic [7:0]  i_cfg_wdata,
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [15:0] i_s_tdata,   // [11:0] line_clock, [15:12] zero
    input  logic [2:0]  i_s_tuser,   // [2:0] action
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [31:0] o_m_tdata    // [15:0] read_data, [24:16] render_line,
                                     // [25] raise_level4, [26] raise_level6, [27] z80_irq
);

    t_cfg                    r_cfg;
    logic                    r_in_valid;
    logic [2:0]              r_in_action;
    logic [LINE_CLOCK_W-1:0] r_in_clock;
    logic                    r_out_valid;
    t_result                 r_out;
    t_result                 core_result;
    logic                    advance;

    assign advance    = r_in_valid && (!r_out_valid || i_m_tready);
    assign o_s_tready = !r_in_valid || advance;
    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = {4'd0, r_out};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= '0;
        end else if (i_cfg_we) begin
            unique case (t_cfg_idx'(i_cfg_addr))
                CFG_LINE_RELOAD:   r_cfg.line_reload   <= i_cfg_wdata;
                CFG_LINE_INT_EN:   r_cfg.line_int_en   <= i_cfg_wdata[0];
                CFG_VBLANK_INT_EN: r_cfg.vblank_int_en <= i_cfg_wdata[0];
                CFG_DISPLAY_EN:    r_cfg.display_en    <= i_cfg_wdata[0];
                CFG_PAL_MODE:      r_cfg.pal_mode      <= i_cfg_wdata[0];
                CFG_WIDE_MODE:     r_cfg.wide_mode     <= i_cfg_wdata[0];
                CFG_PAL_CONSOLE:   r_cfg.pal_console   <= i_cfg_wdata[0];
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (o_s_tready) begin
                r_in_valid <= i_s_tvalid;
            end
            if (advance) begin
                r_out_valid <= 1'b1;
            end else if (i_m_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_s_tvalid && o_s_tready) begin
            r_in_action <= i_s_tuser;
            r_in_clock  <= i_s_tdata[LINE_CLOCK_W-1:0];
        end
        if (advance) begin
            r_out <= core_result;
        end
    end

    vlti_core #(
        .MASTER_CLOCKS_PER_LINE(MASTER_CLOCKS_PER_LINE)
    ) u_core (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (r_cfg),
        .i_step      (advance),
        .i_action    (r_in_action),
        .i_line_clock(r_in_clock),
        .o_result    (core_result)
    );

`ifndef SYNTH
    a_out_from_stage: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> $past(r_in_valid))
        else $error("result appeared without a staged item");

    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !i_m_tready) |=> (r_out_valid && $stable(r_out)))
        else $error("stalled result overwritten");

    a_stage_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_in_valid && !advance)
            |=> (r_in_valid && $stable(r_in_action) && $stable(r_in_clock)))
        else $error("staged item changed while stalled");
`endif

endmodule

>>> verif/tb_video_line_timing_and_interrupts_top.sv
module tb_video_line_timing_and_interrupts_top;
    timeunit 1ns;
    timeprecision 1ps;
    import vlti_pkg::*;

    localparam logic [2:0] ACT_UNUSED_LO  = 3'd5;
    localparam logic [2:0] ACT_UNUSED_MID = 3'd6;
    localparam logic [2:0] ACT_UNUSED_HI  = 3'd7;
    localparam int         QUIET_LIMIT   = 5000;
    localparam int         HOLD_CYCLES   = 80;
    localparam int         PHASE_ITEMS   = 90;

    typedef struct packed {
        logic [2:0]  act;
        logic [11:0] lclk;
    } t_timing_evt;

    logic        i_clk       = 1'b0;
    logic        i_rst_n     = 1'b0;
    logic        i_cfg_we    = 1'b0;
    logic [2:0]  i_cfg_addr  = '0;
    logic [7:0]  i_cfg_wdata = '0;
    logic        i_s_tvalid  = 1'b0;
    logic        o_s_tready;
    logic [15:0] i_s_tdata   = '0;   // [11:0] line_clock, [15:12] zero
    logic [2:0]  i_s_tuser   = '0;   // [2:0] action
    logic        o_m_tvalid;
    logic        i_m_tready  = 1'b0;
    logic [31:0] o_m_tdata;          // [15:0] read_data, [24:16] render_line,
                                     // [25] raise_level4, [26] raise_level6, [27] z80_irq

    video_line_timing_and_interrupts_top u_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_addr (i_cfg_addr),
        .i_cfg_wdata(i_cfg_wdata),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .i_s_tuser  (i_s_tuser),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata)
    );

    always #5 i_clk = ~i_clk;

    // shadow copy of the configuration and the line state
    logic [7:0] sh_reload    = '0;
    bit         sh_line_ie   = 1'b0;
    bit         sh_vblank_ie = 1'b0;
    bit         sh_disp_en   = 1'b0;
    bit         sh_pal_mode  = 1'b0;
    bit         sh_wide      = 1'b0;
    bit         sh_pal_con   = 1'b0;
    logic [8:0] sh_line      = '0;
    int         sh_countdown = 0;
    bit         sh_hint      = 1'b0;
    bit         sh_vint      = 1'b0;
    bit         sh_z80       = 1'b0;

    t_timing_evt pending_evts[$];
    t_result     expected_words[$];
    t_timing_evt drv_next;
    t_result     want;
    t_result     got;

    int tx_idle_pct = 0;
    int rx_idle_pct = 0;
    int hold_asked  = 0;
    int hold_served = 0;
    int hold_left   = 0;
    int quiet_cycles = 0;
    int n_bad       = 0;

    function automatic logic [8:0] h_position(input logic [11:0] lclk);
        int unsigned cl;
        int unsigned p;
        cl = lclk;
        if (sh_wide) begin
            p = cl * 420 / MCLK_PER_LINE_DEFAULT + 'hD;
            if (p >= 'h16D) p += 'h1C9 - 'h16D;
        end else begin
            p = cl * 342 / MCLK_PER_LINE_DEFAULT + 'hB;
            if (p >= 'h128) p += 'h1D2 - 'h128;
        end
        return p[8:0];
    endfunction

    function automatic logic [8:0] v_position();
        int unsigned v;
        v = sh_line;
        if (sh_pal_con && sh_pal_mode && v >= 'h10B)
            v += 'h1D2 - 'h10B;
        else if (sh_pal_con && !sh_pal_mode && v >= 'h103)
            v += 'h1CA - 'h103;
        else if (!sh_pal_con && v >= 'hEB)
            v += 'h1E5 - 'hEB;
        return v[8:0];
    endfunction

    // apply one event to the shadow state and return the word it produces
    function automatic t_result advance_timing(input logic [2:0] act, input logic [11:0] lclk);
        t_result    r;
        logic [8:0] vbs;
        logic [8:0] total;
        logic [8:0] hc;
        logic [8:0] vc;
        bit         vb;
        bit         hb;
        r = '0;
        r.render_line = sh_line;
        vbs   = sh_pal_mode ? 9'h0F0 : 9'h0E0;
        total = sh_pal_con ? 9'd313 : 9'd262;
        hc = h_position(lclk);
        vc = v_position();
        case (act)
            ACT_LINE_END: begin
                if (sh_line == 9'd0 || sh_line >= vbs + 9'd1)
                    sh_countdown = sh_reload;
                sh_countdown--;
                if (sh_countdown < 0) begin
                    if (sh_line_ie && sh_line <= vbs) begin
                        sh_hint = 1'b1;
                        // vblank pending masks the line request
                        if (!sh_vint) r.raise_level4 = 1'b1;
                    end
                    sh_countdown = sh_reload;
                end
                sh_line = sh_line + 9'd1;
                if (sh_line >= total) sh_line = '0;
                if (sh_line == vbs) begin
                    if (sh_vblank_ie) begin
                        sh_vint = 1'b1;
                        r.raise_level6 = 1'b1;
                    end
                    sh_z80 = 1'b1;
                end
                if (sh_line == vbs + 9'd1) sh_z80 = 1'b0;
            end
            ACT_ACK6: begin
                sh_vint = 1'b0;
                r.read_data = sh_hint ? ACK_HINT_PENDING : 16'h0000;
            end
            ACT_ACK4: sh_hint = 1'b0;
            ACT_STATUS: begin
                vb = !sh_disp_en || (vc >= vbs && vc < 9'h1FF);
                hb = sh_wide ? (hc < 9'h00A || hc >= 9'h166) : (hc < 9'h009 || hc >= 9'h126);
                r.read_data = STATUS_BASE | FIFO_EMPTY | (16'(sh_vint) << 7)
                            | (16'(vb) << 3) | (16'(hb) << 2) | 16'(sh_pal_mode);
            end
            ACT_HV_READ: r.read_data = {vc[7:0], hc[8:1]};
            default: ;
        endcase
        r.z80_irq = sh_z80;
        return r;
    endfunction

    function automatic void cmp_field(input string name, input int unsigned exp_v,
                                      input int unsigned act_v);
        if (exp_v != act_v) begin
            $display("%0t: %s expected %0h actual %0h", $time, name, exp_v, act_v);
            n_bad++;
        end
    endfunction

    // driver
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_s_tvalid <= 1'b0;
        end else begin
            if (i_s_tvalid && o_s_tready)
                expected_words.push_back(advance_timing(i_s_tuser, i_s_tdata[11:0]));
            if (!i_s_tvalid || o_s_tready) begin
                if (pending_evts.size() != 0 && $urandom_range(0, 99) >= tx_idle_pct) begin
                    drv_next = pending_evts.pop_front();
                    i_s_tvalid <= 1'b1;
                    i_s_tdata  <= {4'b0000, drv_next.lclk};
                    i_s_tuser  <= drv_next.act;
                end else begin
                    i_s_tvalid <= 1'b0;
                end
            end
        end
    end

    // monitor
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_m_tready <= 1'b0;
        end else begin
            if (o_m_tvalid && i_m_tready) begin
                if (expected_words.size() == 0) begin
                    $display("%0t: result with none expected, actual %h", $time, o_m_tdata);
                    n_bad++;
                end else begin
                    want = expected_words.pop_front();
                    got  = o_m_tdata[27:0];
                    cmp_field("read_data", want.read_data, got.read_data);
                    cmp_field("render_line", want.render_line, got.render_line);
                    cmp_field("raise_level4", want.raise_level4, got.raise_level4);
                    cmp_field("raise_level6", want.raise_level6, got.raise_level6);
                    cmp_field("z80_irq", want.z80_irq, got.z80_irq);
                end
            end
            if (hold_served != hold_asked) begin
                hold_served = hold_asked;
                hold_left   = HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                hold_left--;
                i_m_tready <= 1'b0;
            end else begin
                i_m_tready <= ($urandom_range(0, 99) >= rx_idle_pct);
            end
        end
    end

    // watchdog
    always @(posedge i_clk) begin
        if ((i_s_tvalid && o_s_tready) || (o_m_tvalid && i_m_tready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles == QUIET_LIMIT) begin
            $display("tb_video_line_timing_and_interrupts_top: errors");
            $finish;
        end
    end

    task automatic set_pace(input int p);
        case (p)
            0: begin tx_idle_pct = 15; rx_idle_pct = 68; end
            1: begin tx_idle_pct = 68; rx_idle_pct = 15; end
            default: begin tx_idle_pct = 0; rx_idle_pct = 0; end
        endcase
    endtask

    task automatic push_evt(input logic [2:0] act, input logic [11:0] lclk);
        pending_evts.push_back(t_timing_evt'{act, lclk});
    endtask

    function automatic logic [11:0] rand_line_clock();
        case ($urandom_range(0, 9))
            0: begin
                case ($urandom_range(0, 3))
                    0: return 12'd0;
                    1: return 12'(MCLK_PER_LINE_DEFAULT - 1);
                    2: return 12'(MCLK_PER_LINE_DEFAULT);
                    default: return 12'hFFF;
                endcase
            end
            1: return 12'($urandom_range(0, 4095));
            default: return 12'($urandom_range(0, MCLK_PER_LINE_DEFAULT - 1));
        endcase
    endfunction

    task automatic push_rand_evt();
        int         pick;
        logic [2:0] act;
        pick = $urandom_range(0, 99);
        if (pick < 55)      act = ACT_LINE_END;
        else if (pick < 65) act = ACT_ACK6;
        else if (pick < 75) act = ACT_ACK4;
        else if (pick < 86) act = ACT_STATUS;
        else if (pick < 97) act = ACT_HV_READ;
        else                act = 3'($urandom_range(ACT_UNUSED_LO, ACT_UNUSED_HI));
        push_evt(act, rand_line_clock());
    endtask

    // hold until no item is queued, offered or awaiting its result
    task automatic wait_idle();
        do @(negedge i_clk);
        while (pending_evts.size() != 0 || i_s_tvalid || expected_words.size() != 0);
        repeat (4) @(negedge i_clk);
    endtask

    task automatic write_reg(input t_cfg_idx idx, input logic [7:0] val);
        @(posedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_addr  <= idx;
        i_cfg_wdata <= val;
        case (idx)
            CFG_LINE_RELOAD:   sh_reload    = val;
            CFG_LINE_INT_EN:   sh_line_ie   = val[0];
            CFG_VBLANK_INT_EN: sh_vblank_ie = val[0];
            CFG_DISPLAY_EN:    sh_disp_en   = val[0];
            CFG_PAL_MODE:      sh_pal_mode  = val[0];
            CFG_WIDE_MODE:     sh_wide      = val[0];
            CFG_PAL_CONSOLE:   sh_pal_con   = val[0];
            default: ;
        endcase
    endtask

    task automatic end_writes();
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    // flags from the top bit down: line int, vblank int, display, pal mode, wide, pal console
    task automatic apply_setup(input logic [7:0] reload, input logic [5:0] flags);
        write_reg(CFG_LINE_RELOAD, reload);
        write_reg(CFG_LINE_INT_EN, {7'd0, flags[5]});
        write_reg(CFG_VBLANK_INT_EN, {7'd0, flags[4]});
        write_reg(CFG_DISPLAY_EN, {7'd0, flags[3]});
        write_reg(CFG_PAL_MODE, {7'd0, flags[2]});
        write_reg(CFG_WIDE_MODE, {7'd0, flags[1]});
        write_reg(CFG_PAL_CONSOLE, {7'd0, flags[0]});
        end_writes();
    endtask

    function automatic logic [7:0] rand_reload();
        case ($urandom_range(0, 3))
            0: return 8'd0;
            1: return 8'hFF;
            2: return 8'($urandom_range(0, 7));
            default: return 8'($urandom_range(0, 255));
        endcase
    endfunction

    // advance the line count to a target, with reads sprinkled in
    task automatic run_lines(input int target);
        int n;
        n = (target > sh_line) ? target - sh_line : 0;
        while (n > 0) begin
            if ($urandom_range(0, 4) == 0) begin
                push_evt($urandom_range(0, 1) ? ACT_STATUS : ACT_HV_READ, rand_line_clock());
            end else begin
                push_evt(ACT_LINE_END, rand_line_clock());
                n--;
            end
        end
    endtask

    initial begin
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        set_pace(0);

        // reset settings: H32, NTSC, display off
        push_evt(ACT_STATUS, 12'd0);
        push_evt(ACT_STATUS, 12'(MCLK_PER_LINE_DEFAULT - 1));
        push_evt(ACT_STATUS, 12'hFFF);
        push_evt(ACT_HV_READ, 12'd0);
        push_evt(ACT_HV_READ, 12'(MCLK_PER_LINE_DEFAULT));
        push_evt(ACT_HV_READ, 12'hFFF);
        push_evt(ACT_HV_READ, 12'h800);
        push_evt(ACT_ACK6, 12'h123);
        push_evt(ACT_ACK4, 12'hFFF);
        push_evt(ACT_UNUSED_LO, 12'hFFF);
        push_evt(ACT_UNUSED_MID, 12'h5A5);
        push_evt(ACT_UNUSED_HI, 12'd0);
        push_evt(ACT_LINE_END, 12'd0);
        push_evt(ACT_STATUS, 12'h555);
        push_evt(ACT_HV_READ, 12'hAAA);
        wait_idle();

        // H40, PAL, everything enabled, largest reload
        apply_setup(8'hFF, 6'b111111);
        push_evt(ACT_STATUS, 12'd0);
        push_evt(ACT_STATUS, 12'hFFF);
        push_evt(ACT_STATUS, 12'(MCLK_PER_LINE_DEFAULT - 1));
        push_evt(ACT_HV_READ, 12'd1365);
        push_evt(ACT_HV_READ, 12'hFFF);
        push_evt(ACT_LINE_END, 12'd0);
        push_evt(ACT_ACK6, 12'd0);
        push_evt(ACT_ACK4, 12'd0);
        push_evt(ACT_STATUS, 12'd2730);
        wait_idle();

        for (int ph = 0; ph < 6; ph++) begin
            set_pace(ph / 2);
            apply_setup(rand_reload(), 6'($urandom));
            // stall the result side while the sender keeps offering
            if (ph == 5) hold_asked++;
            repeat (PHASE_ITEMS) push_rand_evt();
            wait_idle();
        end

        // shorten the frame while the line count sits past the short frame length
        apply_setup(rand_reload(), {5'($urandom), 1'b1});
        run_lines(290);
        push_evt(ACT_HV_READ, rand_line_clock());
        wait_idle();
        write_reg(CFG_PAL_CONSOLE, 8'd0);
        end_writes();
        repeat (3) push_evt(ACT_LINE_END, rand_line_clock());
        push_evt(ACT_STATUS, rand_line_clock());
        push_evt(ACT_HV_READ, rand_line_clock());
        wait_idle();

        repeat (10) @(posedge i_clk);
        if (n_bad == 0 && expected_words.size() == 0)
            $display("tb_video_line_timing_and_interrupts_top: clean");
        else
            $display("tb_video_line_timing_and_interrupts_top: errors");
        $finish;
    end

endmodule

>>> files.f
rtl/vlti_pkg.sv
rtl/vlti_hv_map.sv
rtl/vlti_core.sv
rtl/video_line_timing_and_interrupts_top.sv
verif/tb_video_line_timing_and_interrupts_top.sv
